// ===== rtl/uts_pkg.sv =====
// ----------------------------------------------------------------------------
// UTF-8 token splitter package
// Item types, byte class constants and decode helpers for the token splitter.
// ----------------------------------------------------------------------------
package uts_pkg;

	localparam int unsigned NUM_W = 16;

	localparam logic [7:0] HIGH_BIT   = 8'h80;
	localparam logic [7:0] LEAD3_MASK = 8'hE0;
	localparam logic [7:0] LEAD2_CODE = 8'hC0;
	localparam logic [7:0] LEAD4_MASK = 8'hF0;
	localparam logic [7:0] LEAD3_CODE = 8'hE0;
	localparam logic [7:0] LEAD5_MASK = 8'hF8;
	localparam logic [7:0] LEAD4_CODE = 8'hF0;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       last_byte;
	} text_item_t;

	typedef struct packed {
		logic [7:0]       token_byte;
		logic             byte_valid;
		logic             token_begin;
		logic             token_finish;
		logic [NUM_W-1:0] token_number;
		logic             text_done;
	} token_item_t;

	// Continuation bytes that follow a lead byte with the high bit set.
	function automatic logic [1:0] follow_count(input logic [7:0] b);
		logic [1:0] n;
		n = 2'd0;
		if ((b & LEAD3_MASK) == LEAD2_CODE) begin
			n = 2'd1;
		end else if ((b & LEAD4_MASK) == LEAD3_CODE) begin
			n = 2'd2;
		end else if ((b & LEAD5_MASK) == LEAD4_CODE) begin
			n = 2'd3;
		end
		return n;
	endfunction

	function automatic logic is_blank(input logic [7:0] b);
		return (b == 8'h20) || (b >= 8'h09 && b <= 8'h0D);
	endfunction

endpackage

// ===== rtl/utf8_token_splitter.sv =====
// ----------------------------------------------------------------------------
// UTF-8 token splitter
// Splits a byte stream into whitespace separated tokens, one UTF-8 character
// per token for bytes with the high bit set, and marks token boundaries.
// ----------------------------------------------------------------------------
//  channel   | direction | handshake                | payload
//  text      | in        | text_valid / text_stall  | text_item  (byte, last flag)
//  token     | out       | token_valid / token_stall| token_item (byte, marks, number)
//  limit     | in        | limit_we                 | limit_data (token limit)
//
// One text item is taken per cycle while text_stall is low; its zero, one or
// two results are written into a four entry result queue in the same cycle
// and leave it one per cycle while token_stall is low. text_stall rises when
// the queue has room for fewer than two results, so both results always fit.
// Reset clears the token state, the queue and sets the token limit to 65535.
// A stall on the token side only fills the queue; no result is ever lost.
module utf8_token_splitter (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      text_valid,
	output logic                      text_stall,
	input  uts_pkg::text_item_t       text_item,
	output logic                      token_valid,
	input  logic                      token_stall,
	output uts_pkg::token_item_t      token_item,
	input  logic                      limit_we,
	input  logic [uts_pkg::NUM_W-1:0] limit_data
);
	import uts_pkg::*;

	localparam int unsigned DEPTH = 4;
	localparam int unsigned PTR_W = $clog2(DEPTH);
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	// Token state
	logic [NUM_W-1:0] limit_q;
	logic [7:0]       held_byte_q;
	logic             held_valid_q;
	logic             held_first_q;
	logic [1:0]       left_q;
	logic             run_q;
	logic [NUM_W-1:0] tok_q;
	logic             drop_q;

	// Result queue
	token_item_t      fifo_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	logic             acc;
	logic             pop;
	logic [1:0]       push_n;
	token_item_t      res_a;
	token_item_t      res_b;

	// Next state
	logic [7:0]       n_byte;
	logic             n_valid;
	logic             n_first;
	logic [1:0]       n_left;
	logic             n_run;
	logic [NUM_W-1:0] n_tok;
	logic             n_drop;

	logic             emit_held;
	logic             emit_fin;
	logic             end_text;
	token_item_t      held_res;
	token_item_t      fin_res;

	assign text_stall  = cnt_q > CNT_W'(DEPTH - 2);
	assign acc         = text_valid && !text_stall;
	assign token_valid = cnt_q != '0;
	assign pop         = token_valid && !token_stall;
	assign token_item  = fifo_q[rd_ptr_q];

	always_comb begin
		logic [7:0] b;
		logic       last;
		logic       cont;
		logic       start;
		b         = text_item.text_byte;
		last      = text_item.last_byte;
		cont      = 1'b0;
		start     = 1'b0;
		n_byte    = held_byte_q;
		n_valid   = held_valid_q;
		n_first   = held_first_q;
		n_left    = left_q;
		n_run     = run_q;
		n_tok     = tok_q;
		n_drop    = drop_q;
		emit_held = 1'b0;
		emit_fin  = 1'b0;
		end_text  = 1'b0;

		// The held byte as it stands, before this item updates it.
		held_res              = '0;
		held_res.token_byte   = held_byte_q;
		held_res.byte_valid   = 1'b1;
		held_res.token_begin  = held_first_q;
		held_res.token_number = tok_q - NUM_W'(1);

		if (drop_q) begin
			n_drop = !last;
		end else if (b == 8'h00) begin
			emit_fin = 1'b1;
			end_text = 1'b1;
			n_drop   = !last;
		end else begin
			if (left_q != 2'd0) begin
				cont   = 1'b1;
				n_left = left_q - 2'd1;
			end else if (is_blank(b)) begin
				n_run = 1'b0;
			end else if ((b & HIGH_BIT) != 8'h00) begin
				start = 1'b1;
			end else if (run_q) begin
				cont = 1'b1;
			end else begin
				start = 1'b1;
			end

			if (start && tok_q >= limit_q) begin
				emit_fin = 1'b1;
				end_text = 1'b1;
				n_drop   = !last;
			end else begin
				if (cont) begin
					emit_held = held_valid_q;
					held_res.token_finish = 1'b0;
					n_byte  = b;
					n_valid = 1'b1;
					n_first = 1'b0;
				end else if (start) begin
					emit_held = held_valid_q;
					held_res.token_finish = 1'b1;
					n_tok   = tok_q + NUM_W'(1);
					n_byte  = b;
					n_valid = 1'b1;
					n_first = 1'b1;
					if ((b & HIGH_BIT) != 8'h00) begin
						n_left = follow_count(b);
						n_run  = 1'b0;
					end else begin
						n_run = 1'b1;
					end
				end else if (!last && held_valid_q) begin
					emit_held = 1'b1;
					held_res.token_finish = 1'b1;
					n_valid = 1'b0;
				end
				if (last) begin
					emit_fin = 1'b1;
					end_text = 1'b1;
				end
			end
		end

		// Closing result of a text: the byte still held, or a bare marker.
		fin_res = '0;
		fin_res.text_done = 1'b1;
		if (n_valid) begin
			fin_res.token_byte   = n_byte;
			fin_res.byte_valid   = 1'b1;
			fin_res.token_begin  = n_first;
			fin_res.token_finish = 1'b1;
			fin_res.token_number = n_tok - NUM_W'(1);
		end

		if (end_text) begin
			n_byte  = '0;
			n_valid = 1'b0;
			n_first = 1'b0;
			n_left  = 2'd0;
			n_run   = 1'b0;
			n_tok   = '0;
		end
	end

	always_comb begin
		res_a  = emit_held ? held_res : fin_res;
		res_b  = fin_res;
		push_n = 2'd0;
		if (acc) begin
			push_n = {1'b0, emit_held} + {1'b0, emit_fin};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q      <= '1;
			held_byte_q  <= '0;
			held_valid_q <= 1'b0;
			held_first_q <= 1'b0;
			left_q       <= 2'd0;
			run_q        <= 1'b0;
			tok_q        <= '0;
			drop_q       <= 1'b0;
		end else begin
			if (limit_we) begin
				limit_q <= limit_data;
			end
			if (acc) begin
				held_byte_q  <= n_byte;
				held_valid_q <= n_valid;
				held_first_q <= n_first;
				left_q       <= n_left;
				run_q        <= n_run;
				tok_q        <= n_tok;
				drop_q       <= n_drop;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PTR_W'(push_n);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			cnt_q <= cnt_q + CNT_W'(push_n) - CNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			fifo_q[wr_ptr_q] <= res_a;
		end
		if (push_n == 2'd2) begin
			fifo_q[wr_ptr_q + PTR_W'(1)] <= res_b;
		end
	end

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(DEPTH))
		else $error("result queue count above depth");

	a_drop_silent: assert property (@(posedge clk) disable iff (!arst_n)
		acc && drop_q |-> push_n == 2'd0)
		else $error("dropped item produced a result");

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		acc && text_item.last_byte && !drop_q |=> !held_valid_q && tok_q == '0)
		else $error("text state not cleared after last item");

	a_char_held: assert property (@(posedge clk) disable iff (!arst_n)
		left_q != 2'd0 |-> held_valid_q && !run_q)
		else $error("open character without held byte");

	a_begin_byte: assert property (@(posedge clk) disable iff (!arst_n)
		token_valid && token_item.token_begin |-> token_item.byte_valid)
		else $error("begin mark on bare done marker");
`endif

endmodule
